// File: rtl/mwg_pkg.sv
`timescale 1ns / 1ps
package mwg_pkg;

  localparam int MaxDimDefault = 4;
  localparam int CfgIdxW       = 4;
  localparam int CfgDataW      = 3;

  typedef enum logic [1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_LOAD_DC = 2'd2,
    ACT_COMPUTE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    WHICH_C  = 2'd0,
    WHICH_DA = 2'd1,
    WHICH_DB = 2'd2
  } which_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE    = 4'd0,
    CFG_ROWS_P  = 4'd1,
    CFG_INNER_Q = 4'd2,
    CFG_COLS_R  = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [15:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         which;
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [39:0] sum;
    logic               last;
  } out_t;

endpackage

// File: rtl/matmul_with_gradients_core.sv
`timescale 1ns / 1ps
// Matrix multiply with gradients on small on-chip stores of A, B and dC (signed
// Q8.8, row-major, address row*MAX_DIM+col). A load transaction writes one
// element and is dropped when its indices fall outside the effective sizes
// (each size register clamps to 1 .. min(MAX_DIM,4)). A compute transaction
// runs a microcoded sequence: mode 0 emits C = A*B, mode 1 emits dA = dC*B^T
// then dB = A^T*dC, row-major, with last set on the final result. Each result
// loops over the inner length: read the stores, register the 16x16 product,
// accumulate into a 40-bit Q24.16 sum; then it is emitted.
// Input stays stalled from the compute transaction until its last result enters
// the output register; a stalled output holds the sequence at its emit step.
// Configuration writes are taken at any time and should be made while idle.
module matmul_with_gradients_core import mwg_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  localparam int DimLim   = (MAX_DIM < 4) ? MAX_DIM : 4;
  localparam int Depth    = MAX_DIM * MAX_DIM;
  localparam int StoreAw  = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [2:0] UpcIdle = 3'd0;
  localparam logic [2:0] UpcRead = 3'd1;
  localparam logic [2:0] UpcMul  = 3'd2;
  localparam logic [2:0] UpcAcc  = 3'd3;
  localparam logic [2:0] UpcEmit = 3'd4;

  typedef enum logic [1:0] {
    COND_START  = 2'd0,
    COND_ALWAYS = 2'd1,
    COND_KLOOP  = 2'd2,
    COND_EMIT   = 2'd3
  } cond_e;

  typedef struct packed {
    logic       rd;
    logic       mul;
    logic       acc;
    logic       emit;
    cond_e      cond;
    logic [2:0] next;
    logic [2:0] target;
  } uword_t;

  function automatic uword_t rom_word(input logic [2:0] upc);
    uword_t w;
    w = '{rd: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b0, cond: COND_START,
          next: UpcRead, target: UpcIdle};
    case (upc)
      UpcRead: begin
        w.rd   = 1'b1;
        w.cond = COND_ALWAYS;
        w.next = UpcMul;
      end
      UpcMul: begin
        w.mul  = 1'b1;
        w.cond = COND_ALWAYS;
        w.next = UpcAcc;
      end
      UpcAcc: begin
        w.acc    = 1'b1;
        w.cond   = COND_KLOOP;
        w.next   = UpcEmit;
        w.target = UpcRead;
      end
      UpcEmit: begin
        w.emit   = 1'b1;
        w.cond   = COND_EMIT;
        w.next   = UpcRead;
        w.target = UpcIdle;
      end
      default: begin
        w.cond = COND_START;
        w.next = UpcRead;
      end
    endcase
    return w;
  endfunction

  function automatic logic [2:0] eff_dim(input logic [2:0] v);
    logic [2:0] r;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (v > 3'(DimLim)) begin
      r = 3'(DimLim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [StoreAw-1:0] addr_of(input logic [1:0] r, input logic [1:0] c);
    logic [7:0] t;
    t = 8'(r) * 8'(MAX_DIM) + 8'(c);
    return t[StoreAw-1:0];
  endfunction

  logic        mode_q;
  logic [2:0]  rows_q, inner_q, cols_q;
  logic [2:0]  dim_p, dim_q, dim_r;
  logic [2:0]  upc_q, upc_d;
  uword_t      uw;
  which_e      phase_q;
  logic [1:0]  i_q, j_q, k_q;
  logic [2:0]  lim_i, lim_j, lim_k;
  logic        i_last, j_last, k_last, run_done;
  logic signed [31:0] prod_q;
  logic signed [39:0] acc_q;
  logic        out_valid_q;
  out_t        out_q;
  logic        can_emit;
  logic        in_acc, start;
  action_e     act;

  logic               a_we, b_we, dc_we;
  logic [StoreAw-1:0] wr_addr, a_raddr, b_raddr, dc_raddr;
  logic [15:0]        a_rdata, b_rdata, dc_rdata;
  logic signed [15:0] op_x, op_y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      rows_q  <= 3'd4;
      inner_q <= 3'd4;
      cols_q  <= 3'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:    mode_q  <= cfg_data_i[0];
        CFG_ROWS_P:  rows_q  <= cfg_data_i;
        CFG_INNER_Q: inner_q <= cfg_data_i;
        CFG_COLS_R:  cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dim_p = eff_dim(rows_q);
  assign dim_q = eff_dim(inner_q);
  assign dim_r = eff_dim(cols_q);

  assign uw         = rom_word(upc_q);
  assign in_ready_o = (upc_q == UpcIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign act        = action_e'(in_data_i.action);
  assign start      = in_acc && (act == ACT_COMPUTE);

  assign wr_addr = addr_of(in_data_i.row, in_data_i.col);
  assign a_we  = in_acc && (act == ACT_LOAD_A) &&
                 ({1'b0, in_data_i.row} < dim_p) && ({1'b0, in_data_i.col} < dim_q);
  assign b_we  = in_acc && (act == ACT_LOAD_B) &&
                 ({1'b0, in_data_i.row} < dim_q) && ({1'b0, in_data_i.col} < dim_r);
  assign dc_we = in_acc && (act == ACT_LOAD_DC) &&
                 ({1'b0, in_data_i.row} < dim_p) && ({1'b0, in_data_i.col} < dim_r);

  always_comb begin
    case (phase_q)
      WHICH_DA: begin
        lim_i = dim_p;
        lim_j = dim_q;
        lim_k = dim_r;
      end
      WHICH_DB: begin
        lim_i = dim_q;
        lim_j = dim_r;
        lim_k = dim_p;
      end
      default: begin
        lim_i = dim_p;
        lim_j = dim_r;
        lim_k = dim_q;
      end
    endcase
  end

  assign i_last   = ({1'b0, i_q} + 3'd1) == lim_i;
  assign j_last   = ({1'b0, j_q} + 3'd1) == lim_j;
  assign k_last   = ({1'b0, k_q} + 3'd1) == lim_k;
  assign run_done = i_last && j_last && (phase_q == (mode_q ? WHICH_DB : WHICH_C));
  assign can_emit = !out_valid_q || out_ready_i;

  always_comb begin
    a_raddr  = addr_of(i_q, k_q);
    b_raddr  = addr_of(k_q, j_q);
    dc_raddr = addr_of(i_q, k_q);
    case (phase_q)
      WHICH_DA: begin
        b_raddr = addr_of(j_q, k_q);
      end
      WHICH_DB: begin
        a_raddr  = addr_of(k_q, i_q);
        dc_raddr = addr_of(k_q, j_q);
      end
      default: ;
    endcase
  end

  mwg_ram #(.WIDTH(16), .DEPTH(Depth)) u_a_store (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (wr_addr),
    .wdata_i (in_data_i.value),
    .re_i    (uw.rd),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mwg_ram #(.WIDTH(16), .DEPTH(Depth)) u_b_store (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (wr_addr),
    .wdata_i (in_data_i.value),
    .re_i    (uw.rd),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mwg_ram #(.WIDTH(16), .DEPTH(Depth)) u_dc_store (
    .clk_i   (clk_i),
    .we_i    (dc_we),
    .waddr_i (wr_addr),
    .wdata_i (in_data_i.value),
    .re_i    (uw.rd),
    .raddr_i (dc_raddr),
    .rdata_o (dc_rdata)
  );

  assign op_x = (phase_q == WHICH_C) ? signed'(a_rdata) : signed'(dc_rdata);
  assign op_y = (phase_q == WHICH_DB) ? signed'(a_rdata) : signed'(b_rdata);

  always_ff @(posedge clk_i) begin
    if (uw.mul) begin
      prod_q <= op_x * op_y;
    end
  end

  always_comb begin
    upc_d = upc_q;
    case (uw.cond)
      COND_START:  upc_d = start ? uw.next : upc_q;
      COND_ALWAYS: upc_d = uw.next;
      COND_KLOOP:  upc_d = k_last ? uw.next : uw.target;
      COND_EMIT: begin
        if (can_emit) begin
          upc_d = run_done ? uw.target : uw.next;
        end
      end
      default: upc_d = UpcIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q   <= UpcIdle;
      phase_q <= WHICH_C;
      i_q     <= 2'd0;
      j_q     <= 2'd0;
      k_q     <= 2'd0;
    end else begin
      upc_q <= upc_d;
      if (start) begin
        phase_q <= mode_q ? WHICH_DA : WHICH_C;
        i_q     <= 2'd0;
        j_q     <= 2'd0;
        k_q     <= 2'd0;
      end
      if (uw.acc) begin
        k_q <= k_last ? 2'd0 : k_q + 2'd1;
      end
      if (uw.emit && can_emit) begin
        if (j_last) begin
          j_q <= 2'd0;
          if (i_last) begin
            i_q <= 2'd0;
            if (phase_q == WHICH_DA) begin
              phase_q <= WHICH_DB;
            end
          end else begin
            i_q <= i_q + 2'd1;
          end
        end else begin
          j_q <= j_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start || (uw.emit && can_emit)) begin
      acc_q <= '0;
    end else if (uw.acc) begin
      acc_q <= acc_q + {{8{prod_q[31]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.emit && can_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.emit && can_emit) begin
      out_q.which   <= phase_q;
      out_q.out_row <= i_q;
      out_q.out_col <= j_q;
      out_q.sum     <= acc_q;
      out_q.last    <= run_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/mwg_ram.sv
`timescale 1ns / 1ps
module mwg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
